FILE: design/radar_detection_to_cartesian_macros.svh
// assertion macros shared by the radar detection to cartesian rtl
// expects clk and rst_n in the scope of each use
`ifndef RADAR_DETECTION_TO_CARTESIAN_MACROS_SVH
`define RADAR_DETECTION_TO_CARTESIAN_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RDC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rdc_pkg.sv
// shared types, constants and helper functions for the detection converter
// no dependencies
`default_nettype none

package rdc_pkg;

  // field and register widths
  localparam int unsigned RANGE_W = 16;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned FLAG_W  = 8;
  localparam int unsigned POS_W   = 17;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned LIM_W   = 13;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned IN_USER_W  = 9;
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SNR_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POINTS    = 2'd1;

  // register reset values
  localparam logic signed [FIELD_W-1:0] SNR_THR_RESET  = 16'sd1280;
  localparam logic [CNT_W-1:0]          MAX_PTS_RESET  = 9'd256;

  // cordic arithmetic
  localparam int unsigned CORDIC_W     = 32;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned STEP_W       = 4;
  localparam int unsigned PROD_W       = 65;
  localparam int unsigned OPA_W        = 33;
  localparam int unsigned RND_W        = 20;

  typedef logic signed [CORDIC_W-1:0] cordic_word_t;

  localparam cordic_word_t CORDIC_ONE = 32'sd652032874;
  localparam logic [STEP_W-1:0] CORDIC_LAST = 4'(CORDIC_STEPS - 1);

  // quarter turn in binary angle units
  localparam logic signed [ANGLE_W-1:0] QUARTER_POS = 16'sd16384;
  localparam logic signed [ANGLE_W-1:0] QUARTER_NEG = -16'sd16384;

  // saturation bounds of a position
  localparam logic signed [RND_W-1:0] POS_MAX = 20'sd65535;
  localparam logic signed [RND_W-1:0] POS_MIN = -20'sd65535;

  // rounding offsets, half up
  localparam logic signed [PROD_W-1:0] RND_HALF_30 = 65'sd1 <<< 29;
  localparam logic signed [PROD_W-1:0] RND_HALF_45 = 65'sd1 <<< 44;

  // request to the rotation unit
  typedef struct packed {
    logic                      start;
    logic signed [ANGLE_W-1:0] angle;
  } cordic_req_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT_AZ,
    ST_ROT_EL,
    ST_MUL_Z,
    ST_MUL_P,
    ST_MUL_X,
    ST_MUL_Y,
    ST_DONE
  } rdc_state_t;

  // arctangent of 2^-i in units of pi/2^31
  function automatic cordic_word_t cordic_atan(input logic [STEP_W-1:0] i);
    cordic_word_t a;
    case (i)
      4'd0:    a = 32'sd536870912;
      4'd1:    a = 32'sd316933406;
      4'd2:    a = 32'sd167458907;
      4'd3:    a = 32'sd85004756;
      4'd4:    a = 32'sd42667331;
      4'd5:    a = 32'sd21354465;
      4'd6:    a = 32'sd10679838;
      4'd7:    a = 32'sd5340245;
      4'd8:    a = 32'sd2670163;
      4'd9:    a = 32'sd1335087;
      4'd10:   a = 32'sd667544;
      4'd11:   a = 32'sd333772;
      4'd12:   a = 32'sd166886;
      4'd13:   a = 32'sd83443;
      4'd14:   a = 32'sd41722;
      4'd15:   a = 32'sd20861;
      default: a = '0;
    endcase
    return a;
  endfunction

  // round a Q30 product to an integer, half up
  function automatic logic signed [RND_W-1:0] round_q30(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + RND_HALF_30;
    return s[30 +: RND_W];
  endfunction

  // round a Q45 product to an integer, half up
  function automatic logic signed [RND_W-1:0] round_q45(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p + RND_HALF_45;
    return s[45 +: RND_W];
  endfunction

  // clamp to the symmetric position range
  function automatic logic [POS_W-1:0] sat_pos(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] c;
    if (v > POS_MAX) begin
      c = POS_MAX;
    end else if (v < POS_MIN) begin
      c = POS_MIN;
    end else begin
      c = v;
    end
    return c[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/radar_detection_to_cartesian.sv
// top level: detection filter, point counter and cartesian conversion
// depends on rdc_pkg, rdc_cordic and the shared assertion macros
//
//  channel  | dir | contents
//  ---------+-----+------------------------------------------------------
//  in_*     | in  | one detection per transfer (spherical, speed, rcs, snr)
//  out_*    | out | one cartesian point per kept detection
//  cfg_*    | in  | register writes: snr threshold, point limit
//
// a kept detection runs from the input transfer to the output register through
// 2 x 16 cordic rotations on the shared rotation unit, each followed by a
// hand-over, 4 passes through the one shared multiplier and a final load;
// in_tready returns only after that load, so a new detection is not taken before then.
// a dropped detection leaves the sequencer idle. in_tready is high only while the sequencer is idle.
// the output register holds a finished point while the next detection is
// taken; the load waits only if that register is still full.
// reset is synchronous: counter cleared, threshold 5 dB, point limit 256.
`default_nettype none
`include "radar_detection_to_cartesian_macros.svh"

module radar_detection_to_cartesian #(
  parameter int unsigned MAX_POINTS = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // range_dist, azimuth, elevation, radial_speed, cross_section, snr_level
  input  wire logic [rdc_pkg::IN_DATA_W-1:0]       in_tdata,
  // ambiguity_flag, new_set
  input  wire logic [rdc_pkg::IN_USER_W-1:0]       in_tuser,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // pos_x, pos_y, pos_z, speed_out, cross_section_out, snr_out, point_index, pad
  output logic [rdc_pkg::OUT_DATA_W-1:0]           out_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_wr_en,
  input  wire logic [rdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rdc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import rdc_pkg::*;

  localparam logic [LIM_W-1:0] MAX_PTS_L = LIM_W'(MAX_POINTS);

  // input field views
  logic [RANGE_W-1:0]         in_range;
  logic signed [ANGLE_W-1:0]  in_az, in_el;
  logic signed [FIELD_W-1:0]  in_spd, in_cs, in_snr;
  logic [FLAG_W-1:0]          in_flag;
  logic                       in_new_set;

  // control
  rdc_state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [CNT_W-1:0]           cnt_eff;
  logic                       accept, keep;
  logic signed [FIELD_W-1:0]  snr_thr_r, snr_thr_nxt;
  logic [CNT_W-1:0]           max_pts_r, max_pts_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_load;

  // payload
  logic [RANGE_W-1:0]         r_r;
  logic signed [ANGLE_W-1:0]  el_r;
  logic signed [FIELD_W-1:0]  spd_r, cs_r, snr_r;
  logic [IDX_W-1:0]           idx_r;
  cordic_word_t               caz_r, saz_r, cel_r, sel_r;
  logic signed [OPA_W-1:0]    p_r, p_nxt;
  logic [POS_W-1:0]           pos_x_r, pos_x_nxt, pos_z_r, pos_z_nxt;
  logic signed [PROD_W-1:0]   prod_r;
  logic [OUT_DATA_W-1:0]      out_data_r, out_data_nxt;

  // shared multiplier
  logic signed [OPA_W-1:0]    mul_a;
  cordic_word_t               mul_b;
  logic                       mul_en;

  // rotation unit
  cordic_req_t                rot_req;
  logic                       rot_done;
  cordic_word_t               rot_cos, rot_sin;

  assign in_range   = in_tdata[15:0];
  assign in_az      = in_tdata[31:16];
  assign in_el      = in_tdata[47:32];
  assign in_spd     = in_tdata[63:48];
  assign in_cs      = in_tdata[79:64];
  assign in_snr     = in_tdata[95:80];
  assign in_flag    = in_tuser[7:0];
  assign in_new_set = in_tuser[8];

  // filter: flag, snr threshold and point limit after an optional set restart
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cnt_eff   = in_new_set ? '0 : cnt_r;
  assign keep      = (in_flag == '0) && (in_snr >= snr_thr_r)
                     && (cnt_eff < max_pts_r)
                     && ({{(LIM_W-CNT_W){1'b0}}, cnt_eff} < MAX_PTS_L);

  rdc_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (rot_req),
    .done_o (rot_done),
    .cos_o  (rot_cos),
    .sin_o  (rot_sin)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rot_req.start = 1'b0;
    rot_req.angle = in_az;
    mul_a         = {{(OPA_W-RANGE_W){1'b0}}, r_r};
    mul_b         = sel_r;
    mul_en        = 1'b0;
    p_nxt         = p_r;
    pos_x_nxt     = pos_x_r;
    pos_z_nxt     = pos_z_r;
    out_load      = 1'b0;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = cnt_eff;
          if (keep) begin
            cnt_nxt       = cnt_eff + 9'd1;
            rot_req.start = 1'b1;
            state_nxt     = ST_ROT_AZ;
          end
        end
      end
      ST_ROT_AZ: begin
        rot_req.angle = el_r;
        if (rot_done) begin
          rot_req.start = 1'b1;
          state_nxt     = ST_ROT_EL;
        end
      end
      ST_ROT_EL: begin
        if (rot_done) begin
          state_nxt = ST_MUL_Z;
        end
      end
      ST_MUL_Z: begin
        // r * sin(el)
        mul_en    = 1'b1;
        state_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        // r * cos(el), z from the previous product
        mul_b     = cel_r;
        mul_en    = 1'b1;
        pos_z_nxt = sat_pos(round_q30(prod_r));
        state_nxt = ST_MUL_X;
      end
      ST_MUL_X: begin
        // ground range times cos(az)
        mul_a     = prod_r[15 +: OPA_W];
        mul_b     = caz_r;
        mul_en    = 1'b1;
        p_nxt     = prod_r[15 +: OPA_W];
        state_nxt = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        // ground range times sin(az), x from the previous product
        mul_a     = p_r;
        mul_b     = saz_r;
        mul_en    = 1'b1;
        pos_x_nxt = sat_pos(round_q45(prod_r));
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load     = 1'b1;
          out_data_nxt = {5'b00000, idx_r, snr_r, cs_r, spd_r,
                          pos_z_r, sat_pos(round_q45(prod_r)), pos_x_r};
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // configuration writes, unknown indexes ignored
  always_comb begin
    snr_thr_nxt = snr_thr_r;
    max_pts_nxt = max_pts_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_SNR_THRESHOLD: snr_thr_nxt = cfg_wdata;
        REG_MAX_POINTS:    max_pts_nxt = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      snr_thr_r   <= SNR_THR_RESET;
      max_pts_r   <= MAX_PTS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      snr_thr_r   <= snr_thr_nxt;
      max_pts_r   <= max_pts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // detection capture on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      r_r   <= in_range;
      el_r  <= in_el;
      spd_r <= in_spd;
      cs_r  <= in_cs;
      snr_r <= in_snr;
      idx_r <= cnt_eff[IDX_W-1:0];
    end
  end

  // rotation results
  always_ff @(posedge clk) begin
    if (rot_done && (state_r == ST_ROT_AZ)) begin
      caz_r <= rot_cos;
      saz_r <= rot_sin;
    end
    if (rot_done && (state_r == ST_ROT_EL)) begin
      cel_r <= rot_cos;
      sel_r <= rot_sin;
    end
  end

  // product register and intermediate results
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    p_r        <= p_nxt;
    pos_x_r    <= pos_x_nxt;
    pos_z_r    <= pos_z_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

  `RDC_ASSERT_NOW(a_rot_done_state, rot_done,
    (state_r == ST_ROT_AZ) || (state_r == ST_ROT_EL), "rotation result outside a rotation")
  `RDC_ASSERT_NOW(a_cnt_bound, 1'b1,
    {{(LIM_W-CNT_W){1'b0}}, cnt_r} <= MAX_PTS_L, "point count above the build limit")
  `RDC_ASSERT_NEXT(a_done_loads, (state_r == ST_DONE) && (state_nxt == ST_IDLE),
    out_valid_r, "finished point not presented")

endmodule

`default_nettype wire

FILE: design/rdc_cordic.sv
// iterative cordic rotation giving cos and sin of a binary angle in Q30
// depends on rdc_pkg and the shared assertion macros
`default_nettype none
`include "radar_detection_to_cartesian_macros.svh"

module rdc_cordic (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rdc_pkg::cordic_req_t req,
  output logic                      done_o,
  output rdc_pkg::cordic_word_t     cos_o,
  output rdc_pkg::cordic_word_t     sin_o
);
  import rdc_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                neg_r, neg_nxt;
  cordic_word_t        x_r, x_nxt;
  cordic_word_t        y_r, y_nxt;
  cordic_word_t        z_r, z_nxt;

  logic                fold;
  logic [ANGLE_W-1:0]  ang_f;
  cordic_word_t        x_sh, y_sh, atan_v;

  // one micro-rotation per cycle, quadrant fold on start
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;

    fold   = (req.angle > QUARTER_POS) || (req.angle < QUARTER_NEG);
    // adding or removing a half turn flips the top bit
    ang_f  = fold ? {~req.angle[ANGLE_W-1], req.angle[ANGLE_W-2:0]} : req.angle;
    x_sh   = x_r >>> step_r;
    y_sh   = y_r >>> step_r;
    atan_v = cordic_atan(step_r);

    if (req.start) begin
      x_nxt    = CORDIC_ONE;
      y_nxt    = '0;
      z_nxt    = {ang_f, 16'h0000};
      neg_nxt  = fold;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[CORDIC_W-1]) begin
        x_nxt = x_r - y_sh;
        y_nxt = y_r + x_sh;
        z_nxt = z_r - atan_v;
      end else begin
        x_nxt = x_r + y_sh;
        y_nxt = y_r - x_sh;
        z_nxt = z_r + atan_v;
      end
      step_nxt = step_r + 4'd1;
      if (step_r == CORDIC_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    neg_r <= neg_nxt;
  end

  // results, negated when the angle was folded
  assign done_o = done_r;
  assign cos_o  = neg_r ? -x_r : x_r;
  assign sin_o  = neg_r ? -y_r : y_r;

  `RDC_ASSERT_NOW(a_start_idle, req.start, !busy_r, "rotation started while busy")
  `RDC_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "done held longer than one cycle")
  `RDC_ASSERT_NOW(a_step_rest, !busy_r, step_r == '0, "step counter not at rest")

endmodule

`default_nettype wire
